FILE: hw/rtl/brq_pkg.sv
// brq_pkg: shared types, codes and a helper function for the bucketed
// range-update / range-query block. No dependencies.
package brq_pkg;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_READ   = 2'd2,
        OP_REDUCE = 2'd3
    } op_t;

    // Reduction modes; any other code acts as a sum.
    localparam logic [1:0] CMB_SUM = 2'd0;
    localparam logic [1:0] CMB_MIN = 2'd1;
    localparam logic [1:0] CMB_MAX = 2'd2;

    // Range update modes.
    localparam logic [1:0] UPD_ADD = 2'd0;
    localparam logic [1:0] UPD_MUL = 2'd1;
    localparam logic [1:0] UPD_AFF = 2'd2;
    localparam logic [1:0] UPD_SET = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COMBINE = 2'd0;
    localparam logic [1:0] CFG_UPDATE  = 2'd1;
    localparam logic [1:0] CFG_COUNT   = 2'd2;
    localparam logic [1:0] CFG_NONE    = 2'd3;

    // Positions are carried at the widest size any configuration needs.
    typedef logic [16:0] pos_t;
    typedef logic [63:0] word_t;

    // One classified request as it travels through the queue.
    typedef struct packed {
        op_t   op;
        logic  skip;
        pos_t  left;
        pos_t  hi;
        word_t fa;
        word_t fb;
        word_t a;
    } item_t;

    // Configuration view needed by the front end.
    typedef struct packed {
        logic [1:0] upd;
        pos_t       used;
    } front_cfg_t;

    // Per-bucket record: lazy map, aggregate and winning position.
    typedef struct packed {
        word_t f;
        word_t o;
        word_t agg;
        pos_t  pos;
        logic  has;
    } bkt_t;

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BKT,
        S_BKT_RD,
        S_CX,
        S_CY,
        S_CW1,
        S_CW2,
        S_PASS_RD,
        S_PASS_MUL,
        S_PASS_WAIT,
        S_PASS_FOLD,
        S_BKT_WR,
        S_RESULT
    } state_t;

    // True when candidate c beats current v under min (or else max).
    function automatic logic better(input word_t c, input word_t v, input logic is_min);
        logic r;
        begin
            if (is_min)
            begin
                r = $signed(c) < $signed(v);
            end
            else
            begin
                r = $signed(c) > $signed(v);
            end
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/brq_mul.sv
// brq_mul: two-stage 64-bit wrapping multiply-add, p = a * b + c.
// Built from three 32x32 partial products. Uses brq_pkg.
module brq_mul (
    input  logic          clk,
    input  brq_pkg::word_t a,
    input  brq_pkg::word_t b,
    input  brq_pkg::word_t c,
    output brq_pkg::word_t p
);
    import brq_pkg::*;

    logic [63:0] p0_reg;
    logic [31:0] p1_reg;
    logic [31:0] p2_reg;
    word_t       c_reg;
    word_t       p_reg;
    logic [63:0] p1_full;
    logic [63:0] p2_full;

    // Partial products; only the low half of the cross terms survives.
    assign p1_full = a[31:0] * b[63:32];
    assign p2_full = a[63:32] * b[31:0];

    // Stage one registers the partial products.
    always_ff @(posedge clk)
    begin
        p0_reg <= a[31:0] * b[31:0];
        p1_reg <= p1_full[31:0];
        p2_reg <= p2_full[31:0];
        c_reg  <= c;
    end

    // Stage two sums them with the addend.
    always_ff @(posedge clk)
    begin
        p_reg <= p0_reg + {p1_reg + p2_reg, 32'd0} + c_reg;
    end

    assign p = p_reg;
endmodule

FILE: hw/rtl/brq_fifo.sv
// brq_fifo: two-entry request queue between the front and back ends.
// Uses brq_pkg for the request type.
module brq_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  brq_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output brq_pkg::item_t head
);
    import brq_pkg::*;

    item_t      mem_reg [2];
    logic       wp_reg;
    logic       wp_next;
    logic       rp_reg;
    logic       rp_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full  = cnt_reg == 2'd2;
    assign valid = cnt_reg != 2'd0;
    assign head  = mem_reg[rp_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage for queued requests.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_item;
        end
    end
endmodule

FILE: hw/rtl/brq_front.sv
// brq_front: accepts input requests, clips ranges and works out the
// update map. Uses brq_pkg; feeds brq_fifo.
module brq_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [11:0]          left,
    input  logic [12:0]          right,
    input  logic [63:0]          operand_a,
    input  logic [63:0]          operand_b,
    input  brq_pkg::front_cfg_t  fcfg,
    input  logic                 fifo_full,
    output logic                 push,
    output brq_pkg::item_t       push_item
);
    import brq_pkg::*;

    pos_t left_x;
    pos_t right_x;
    pos_t hi_clip;
    logic is_point;
    op_t  op_c;

    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full;
    assign op_c     = op_t'(op);
    assign left_x   = pos_t'(left);
    assign right_x  = pos_t'(right);
    assign hi_clip  = (right_x < fcfg.used) ? right_x : fcfg.used;
    assign is_point = (op_c == OP_LOAD) || (op_c == OP_READ);

    // Classify the request: range bounds, empty check and update map.
    always_comb
    begin
        push_item.op   = op_c;
        push_item.left = left_x;
        push_item.a    = operand_a;
        if (is_point)
        begin
            push_item.hi   = left_x + pos_t'(1);
            push_item.skip = left_x >= fcfg.used;
        end
        else
        begin
            push_item.hi   = hi_clip;
            push_item.skip = left_x >= hi_clip;
        end
        case (fcfg.upd)
            UPD_ADD:
            begin
                push_item.fa = 64'd1;
                push_item.fb = operand_a;
            end
            UPD_MUL:
            begin
                push_item.fa = operand_a;
                push_item.fb = 64'd0;
            end
            UPD_AFF:
            begin
                push_item.fa = operand_a;
                push_item.fb = operand_b;
            end
            default:
            begin
                push_item.fa = 64'd0;
                push_item.fb = operand_a;
            end
        endcase
    end
endmodule

FILE: hw/rtl/brq_back.sv
// brq_back: sequencer that walks buckets and elements, owns the element and
// bucket memories, the configuration registers and the result register.
// Uses brq_pkg and brq_mul.
module brq_back #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int BUCKET_SIZE  = 64,
    parameter int BUCKET_COUNT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data,
    input  logic                q_valid,
    input  brq_pkg::item_t      q_item,
    output logic                q_pop,
    output brq_pkg::front_cfg_t fcfg,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         result_value,
    output logic [12:0]         best_position
);
    import brq_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int POS_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int BKT_W  = $clog2(BUCKET_COUNT);
    localparam int J_W    = $clog2(BUCKET_SIZE);
    localparam int CW     = (POS_W > 13) ? POS_W : 13;
    localparam logic [POS_W-1:0]  BS_P   = POS_W'(BUCKET_SIZE);
    localparam logic [POS_W-1:0]  MAX_P  = POS_W'(MAX_ELEMENTS);
    localparam logic [BKT_W-1:0]  LAST_K = BKT_W'(BUCKET_COUNT - 1);
    localparam logic [J_W-1:0]    LAST_J = J_W'(BUCKET_SIZE - 1);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(MAX_ELEMENTS - 1);
    localparam logic [ADDR_W-1:0] BC_A   = ADDR_W'(BUCKET_COUNT);

    // Memories.
    word_t elem_mem [MAX_ELEMENTS];
    bkt_t  bkt_mem  [BUCKET_COUNT];
    word_t elem_q;
    bkt_t  bkt_q;

    // Registers.
    state_t            state_reg,     state_next;
    logic [1:0]        comb_reg,      comb_next;
    logic [1:0]        upd_reg,       upd_next;
    logic [12:0]       cnt_reg,       cnt_next;
    item_t             item_reg,      item_next;
    logic              refresh_reg,   refresh_next;
    logic [BKT_W-1:0]  k_reg,         k_next;
    logic [POS_W-1:0]  lo_reg,        lo_next;
    logic [J_W-1:0]    j_reg,         j_next;
    logic              wr_reg,        wr_next;
    word_t             base_f_reg,    base_f_next;
    word_t             base_o_reg,    base_o_next;
    word_t             rng_f_reg,     rng_f_next;
    word_t             rng_o_reg,     rng_o_next;
    word_t             q_acc_reg,     q_acc_next;
    logic [POS_W-1:0]  q_pos_reg,     q_pos_next;
    logic              q_has_reg,     q_has_next;
    word_t             b_acc_reg,     b_acc_next;
    logic [POS_W-1:0]  b_pos_reg,     b_pos_next;
    logic              b_has_reg,     b_has_next;
    word_t             cap_reg,       cap_next;
    logic [ADDR_W-1:0] clr_reg,       clr_next;
    logic              out_valid_reg, out_valid_next;
    word_t             out_value_reg, out_value_next;
    logic [12:0]       out_pos_reg,   out_pos_next;

    // Combinational helpers.
    logic [POS_W-1:0]  used_n;
    logic [POS_W-1:0]  left_p;
    logic [POS_W-1:0]  hi_p;
    logic [POS_W-1:0]  idx;
    logic [POS_W-1:0]  lo_end;
    logic              is_sum;
    logic              is_min;
    logic              in_rng;
    logic              whole;
    logic              last_bkt;
    logic              skip_bkt;
    logic              has_result;
    logic              out_free;
    logic              cfg_hit;
    logic              use_rng;
    word_t             mul_a;
    word_t             mul_b;
    word_t             mul_c;
    word_t             mul_p;
    word_t             elem_v;
    logic              elem_we;
    logic [ADDR_W-1:0] elem_wa;
    word_t             elem_wd;
    logic              bkt_we;
    logic [BKT_W-1:0]  bkt_wa;
    bkt_t              bkt_wd;
    logic [ADDR_W-1:0] elem_ra;

    brq_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .c   (mul_c),
        .p   (mul_p)
    );

    // Decode of the current position within the walk.
    assign used_n     = (CW'(cnt_reg) > CW'(MAX_ELEMENTS)) ? MAX_P : POS_W'(cnt_reg);
    assign left_p     = item_reg.left[POS_W-1:0];
    assign hi_p       = item_reg.hi[POS_W-1:0];
    assign idx        = lo_reg + POS_W'(j_reg);
    assign lo_end     = lo_reg + BS_P;
    assign is_sum     = (comb_reg != CMB_MIN) && (comb_reg != CMB_MAX);
    assign is_min     = comb_reg == CMB_MIN;
    assign in_rng     = (idx >= left_p) && (idx < hi_p);
    assign whole      = !refresh_reg && (left_p <= lo_reg) && (lo_end <= hi_p)
                        && ((item_reg.op == OP_UPDATE) || (item_reg.op == OP_REDUCE));
    assign last_bkt   = refresh_reg ? (k_reg == LAST_K) : (lo_end >= hi_p);
    assign skip_bkt   = !refresh_reg && (lo_end <= left_p);
    assign has_result = !refresh_reg
                        && ((item_reg.op == OP_READ) || (item_reg.op == OP_REDUCE));
    assign out_free   = !out_valid_reg || out_ready;
    assign cfg_ready  = (state_reg == S_IDLE) && !q_valid;
    assign cfg_hit    = cfg_valid && cfg_ready;
    assign q_pop      = (state_reg == S_IDLE) && q_valid && !cfg_hit;
    assign use_rng    = (item_reg.op == OP_UPDATE) && !refresh_reg && wr_reg && in_rng;
    assign elem_v     = ((item_reg.op == OP_LOAD) && !refresh_reg && (idx == left_p))
                        ? item_reg.a : mul_p;
    assign elem_ra    = idx[ADDR_W-1:0];

    assign fcfg.upd   = upd_reg;
    assign fcfg.used  = pos_t'(used_n);

    assign out_valid     = out_valid_reg;
    assign result_value  = out_value_reg;
    assign best_position = out_pos_reg;

    // Multiplier operand selection: map composition or element mapping.
    always_comb
    begin
        case (state_reg)
            S_CX:
            begin
                mul_a = item_reg.fa;
                mul_b = base_f_reg;
                mul_c = 64'd0;
            end
            S_CY:
            begin
                mul_a = item_reg.fa;
                mul_b = base_o_reg;
                mul_c = item_reg.fb;
            end
            default:
            begin
                mul_a = use_rng ? rng_f_reg : base_f_reg;
                mul_b = elem_q;
                mul_c = use_rng ? rng_o_reg : base_o_reg;
            end
        endcase
    end

    // Memory write ports.
    always_comb
    begin
        elem_we = (state_reg == S_CLEAR) || ((state_reg == S_PASS_FOLD) && wr_reg);
        elem_wa = (state_reg == S_CLEAR) ? clr_reg : idx[ADDR_W-1:0];
        elem_wd = (state_reg == S_CLEAR) ? 64'd0 : elem_v;
        bkt_we  = ((state_reg == S_CLEAR) && (clr_reg < BC_A)) || (state_reg == S_BKT_WR);
        bkt_wa  = (state_reg == S_CLEAR) ? clr_reg[BKT_W-1:0] : k_reg;
        if (state_reg == S_CLEAR)
        begin
            bkt_wd.f   = 64'd1;
            bkt_wd.o   = 64'd0;
            bkt_wd.agg = 64'd0;
            bkt_wd.pos = pos_t'(0);
            bkt_wd.has = 1'b0;
        end
        else
        begin
            bkt_wd.f   = wr_reg ? 64'd1 : base_f_reg;
            bkt_wd.o   = wr_reg ? 64'd0 : base_o_reg;
            bkt_wd.agg = b_acc_reg;
            bkt_wd.pos = pos_t'(b_pos_reg);
            bkt_wd.has = b_has_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_wa] <= elem_wd;
        end
        elem_q <= elem_mem[elem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_wa] <= bkt_wd;
        end
        bkt_q <= bkt_mem[k_reg];
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST_A)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_hit)
                begin
                    if (cfg_index != CFG_NONE)
                    begin
                        state_next = S_BKT;
                    end
                end
                else if (q_valid)
                begin
                    if (!q_item.skip)
                    begin
                        state_next = S_BKT;
                    end
                    else if ((q_item.op == OP_READ) || (q_item.op == OP_REDUCE))
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_BKT:
            begin
                if (!skip_bkt)
                begin
                    state_next = S_BKT_RD;
                end
            end
            S_BKT_RD:
            begin
                if (whole && (item_reg.op == OP_REDUCE))
                begin
                    if (last_bkt)
                    begin
                        state_next = has_result ? S_RESULT : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_BKT;
                    end
                end
                else if (!refresh_reg && (item_reg.op == OP_UPDATE))
                begin
                    state_next = S_CX;
                end
                else
                begin
                    state_next = S_PASS_RD;
                end
            end
            S_CX:        state_next = S_CY;
            S_CY:        state_next = S_CW1;
            S_CW1:       state_next = S_CW2;
            S_CW2:       state_next = S_PASS_RD;
            S_PASS_RD:   state_next = S_PASS_MUL;
            S_PASS_MUL:  state_next = S_PASS_WAIT;
            S_PASS_WAIT: state_next = S_PASS_FOLD;
            S_PASS_FOLD:
            begin
                state_next = (j_reg == LAST_J) ? S_BKT_WR : S_PASS_RD;
            end
            S_BKT_WR:
            begin
                if (last_bkt)
                begin
                    state_next = has_result ? S_RESULT : S_IDLE;
                end
                else
                begin
                    state_next = S_BKT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath and output register updates per state.
    always_comb
    begin
        comb_next      = comb_reg;
        upd_next       = upd_reg;
        cnt_next       = cnt_reg;
        item_next      = item_reg;
        refresh_next   = refresh_reg;
        k_next         = k_reg;
        lo_next        = lo_reg;
        j_next         = j_reg;
        wr_next        = wr_reg;
        base_f_next    = base_f_reg;
        base_o_next    = base_o_reg;
        rng_f_next     = rng_f_reg;
        rng_o_next     = rng_o_reg;
        q_acc_next     = q_acc_reg;
        q_pos_next     = q_pos_reg;
        q_has_next     = q_has_reg;
        b_acc_next     = b_acc_reg;
        b_pos_next     = b_pos_reg;
        b_has_next     = b_has_reg;
        cap_next       = cap_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_pos_next   = out_pos_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
            end
            S_IDLE:
            begin
                if (cfg_hit)
                begin
                    // Register write; any known register starts a recompute.
                    case (cfg_index)
                        CFG_COMBINE: comb_next = cfg_data[1:0];
                        CFG_UPDATE:  upd_next  = cfg_data[1:0];
                        CFG_COUNT:   cnt_next  = cfg_data;
                        default:     cnt_next  = cnt_reg;
                    endcase
                    refresh_next = 1'b1;
                    k_next       = '0;
                    lo_next      = '0;
                end
                else if (q_valid)
                begin
                    item_next    = q_item;
                    refresh_next = 1'b0;
                    k_next       = '0;
                    lo_next      = '0;
                    q_acc_next   = 64'd0;
                    q_pos_next   = '0;
                    q_has_next   = 1'b0;
                    cap_next     = 64'd0;
                end
            end
            S_BKT:
            begin
                if (skip_bkt)
                begin
                    k_next  = k_reg + BKT_W'(1);
                    lo_next = lo_end;
                end
            end
            S_BKT_RD:
            begin
                base_f_next = bkt_q.f;
                base_o_next = bkt_q.o;
                b_acc_next  = 64'd0;
                b_pos_next  = '0;
                b_has_next  = 1'b0;
                j_next      = '0;
                wr_next     = !refresh_reg && !whole;
                if (whole && (item_reg.op == OP_REDUCE))
                begin
                    // Whole bucket folds its stored aggregate.
                    if (is_sum)
                    begin
                        q_acc_next = q_acc_reg + bkt_q.agg;
                    end
                    else if (bkt_q.has && (!q_has_reg || better(bkt_q.agg, q_acc_reg, is_min)))
                    begin
                        q_acc_next = bkt_q.agg;
                        q_pos_next = bkt_q.pos[POS_W-1:0];
                        q_has_next = 1'b1;
                    end
                    if (!last_bkt)
                    begin
                        k_next  = k_reg + BKT_W'(1);
                        lo_next = lo_end;
                    end
                end
            end
            S_CW1:
            begin
                if (wr_reg)
                begin
                    rng_f_next = mul_p;
                end
                else
                begin
                    base_f_next = mul_p;
                end
            end
            S_CW2:
            begin
                if (wr_reg)
                begin
                    rng_o_next = mul_p;
                end
                else
                begin
                    base_o_next = mul_p;
                end
            end
            S_PASS_FOLD:
            begin
                // Bucket aggregate over in-use positions.
                if (idx < used_n)
                begin
                    if (is_sum)
                    begin
                        b_acc_next = b_acc_reg + elem_v;
                    end
                    else if (!b_has_reg || better(elem_v, b_acc_reg, is_min))
                    begin
                        b_acc_next = elem_v;
                        b_pos_next = idx;
                        b_has_next = 1'b1;
                    end
                end
                // Query fold over the covered part of a partial bucket.
                if ((item_reg.op == OP_REDUCE) && !refresh_reg && in_rng)
                begin
                    if (is_sum)
                    begin
                        q_acc_next = q_acc_reg + elem_v;
                    end
                    else if (!q_has_reg || better(elem_v, q_acc_reg, is_min))
                    begin
                        q_acc_next = elem_v;
                        q_pos_next = idx;
                        q_has_next = 1'b1;
                    end
                end
                if ((item_reg.op == OP_READ) && !refresh_reg && (idx == left_p))
                begin
                    cap_next = elem_v;
                end
                j_next = j_reg + J_W'(1);
            end
            S_BKT_WR:
            begin
                if (!last_bkt)
                begin
                    k_next  = k_reg + BKT_W'(1);
                    lo_next = lo_end;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (item_reg.op == OP_READ)
                    begin
                        out_value_next = cap_reg;
                        out_pos_next   = '1;
                    end
                    else if (is_sum)
                    begin
                        out_value_next = q_acc_reg;
                        out_pos_next   = '1;
                    end
                    else if (q_has_reg)
                    begin
                        out_value_next = q_acc_reg;
                        out_pos_next   = 13'(q_pos_reg);
                    end
                    else
                    begin
                        out_value_next = 64'd0;
                        out_pos_next   = '1;
                    end
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            comb_reg      <= CMB_SUM;
            upd_reg       <= UPD_ADD;
            cnt_reg       <= 13'd4096;
            refresh_reg   <= 1'b0;
            k_reg         <= '0;
            lo_reg        <= '0;
            j_reg         <= '0;
            wr_reg        <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            comb_reg      <= comb_next;
            upd_reg       <= upd_next;
            cnt_reg       <= cnt_next;
            refresh_reg   <= refresh_next;
            k_reg         <= k_next;
            lo_reg        <= lo_next;
            j_reg         <= j_next;
            wr_reg        <= wr_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        base_f_reg    <= base_f_next;
        base_o_reg    <= base_o_next;
        rng_f_reg     <= rng_f_next;
        rng_o_reg     <= rng_o_next;
        q_acc_reg     <= q_acc_next;
        q_pos_reg     <= q_pos_next;
        q_has_reg     <= q_has_next;
        b_acc_reg     <= b_acc_next;
        b_pos_reg     <= b_pos_next;
        b_has_reg     <= b_has_next;
        cap_reg       <= cap_next;
        out_value_reg <= out_value_next;
        out_pos_reg   <= out_pos_next;
    end

    // Element memory is written only by the clearing pass or a writing walk.
    a_elem_we: assert property (@(posedge clk) disable iff (!rst_n)
        elem_we |-> ((state_reg == S_CLEAR) || ((state_reg == S_PASS_FOLD) && wr_reg)))
        else $error("element write outside clear or writing walk");

    // A result appears only after the sequencer reaches its result step.
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_RESULT))
        else $error("result raised outside result step");

    // The bucket walk never runs past the element array.
    a_lo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BKT_RD) |-> (lo_reg < MAX_P))
        else $error("bucket walk beyond element array");

    // No request is taken from the queue while a configuration write lands.
    a_pop_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && cfg_hit))
        else $error("queue pop together with configuration write");
endmodule

FILE: hw/rtl/bucketed_range_update_range_query.sv
// Channel  | signals                                        | direction
// in       | in_valid/in_ready, op, left, right, operand_a/b | request in
// out      | out_valid/out_ready, result_value, best_position| result out
// cfg      | cfg_valid/cfg_ready, cfg_index, cfg_data        | register write
//
// After reset a clearing pass zeroes the element memory;
// requests queue up but none is executed until it ends.
// A request skips buckets below its range, reduces whole buckets from their stored
// aggregates and walks element by element through partial buckets of a reduction,
// the buckets of loads and reads and every bucket a range update covers; a range
// update first composes the update into the bucket's map. Each element step is
// bound by the element memory read and the two-stage multiply. A register write
// recomputes all buckets. A two-entry queue and the result register let either
// side stall independently.
// Top level; uses brq_pkg, brq_front, brq_fifo and brq_back.
module bucketed_range_update_range_query #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int BUCKET_SIZE  = 64,
    parameter int BUCKET_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [11:0] left,
    input  logic [12:0] right,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_value,
    output logic [12:0] best_position,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import brq_pkg::*;

    front_cfg_t fcfg;
    item_t      push_item;
    item_t      head;
    logic       push;
    logic       full;
    logic       q_valid;
    logic       q_pop;

    // Front end: accept and classify requests.
    brq_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .left      (left),
        .right     (right),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .fcfg      (fcfg),
        .fifo_full (full),
        .push      (push),
        .push_item (push_item)
    );

    // Request queue.
    brq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head)
    );

    // Back end: bucket sequencer and memories.
    brq_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .BUCKET_SIZE  (BUCKET_SIZE),
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_item        (head),
        .q_pop         (q_pop),
        .fcfg          (fcfg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_value  (result_value),
        .best_position (best_position)
    );
endmodule
